FILE: hw/rtl/ibpa_pkg.sv
package ibpa_pkg;

    localparam int STORE_BYTES = 65536;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int MAX_PLANES  = 8;

    // operation codes
    localparam logic [1:0] FN_RD_PIX = 2'd0;
    localparam logic [1:0] FN_WR_PIX = 2'd1;
    localparam logic [1:0] FN_RD_BIT = 2'd2;
    localparam logic [1:0] FN_WR_BIT = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_WPR   = 2'd1;
    localparam logic [1:0] CFG_PLN   = 2'd2;

    localparam int CFG_DW = 16;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] x;
        logic [11:0] y;
        logic [2:0]  plane;
        logic [7:0]  value;
    } t_req;

    typedef struct packed {
        logic [15:0] byte_address;
        logic [7:0]  bit_mask;
        logic [7:0]  read_value;
    } t_res;

endpackage

FILE: hw/rtl/ibpa_ram.sv
module ibpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ibpa_mac.sv
module ibpa_mac import ibpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic [STORE_AW-1:0] i_a,
    input  logic [8:0]          i_b,
    input  logic [STORE_AW-1:0] i_c,
    output logic [STORE_AW-1:0] o_y
);

    logic [STORE_AW+8:0]  w_prod;
    logic [STORE_AW-1:0]  n_y;
    logic [STORE_AW-1:0]  r_y;

    // product and sum wrap to the store size
    assign w_prod = {9'd0, i_a} * {{STORE_AW{1'b0}}, i_b};
    assign n_y    = w_prod[STORE_AW-1:0] + i_c;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

FILE: hw/rtl/interleaved_bitplane_pixel_access.sv
// Channel   Ports                         Transfer
// request   i_start, i_req  -> o_busy     i_start high while o_busy low
// result    o_done, o_res                 o_done high for one cycle
// config    i_cfg_we, i_cfg_idx, i_cfg_data  i_cfg_we high
//
// An item goes from the transfer through ST_MUL0 and ST_MUL1, where the shared
// multiply-add unit forms the address, to ST_ACC, which handles N planes, where N
// is the effective plane count for pixel operations and 1 for plane-bit ones.
// There one frame store byte is read per cycle, with a write in the cycle after
// its read on the store's second port. o_busy is high after the transfer until
// the result cycle. Reset is synchronous, active low; the frame store is not
// cleared. The receiver cannot stall results.
module interleaved_bitplane_pixel_access import ibpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  t_req              i_req,
    output logic              o_done,
    output t_res              o_res,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL0 = 2'd1;
    localparam logic [1:0] ST_MUL1 = 2'd2;
    localparam logic [1:0] ST_ACC  = 2'd3;

    logic [15:0] r_base;
    logic [8:0]  r_wpr;
    logic [3:0]  r_pln;

    logic [1:0]  r_state, n_state;
    t_req        r_req;
    logic [7:0]  r_mask;
    logic [3:0]  r_cnt, n_cnt;
    logic [3:0]  r_iss, n_iss;
    logic        r_rv, n_rv;
    logic [2:0]  r_rp, n_rp;
    logic [7:0]  r_rval, n_rval;
    logic        r_done, n_done;
    t_res        r_res, n_res;

    logic [3:0]          w_np;
    logic                w_load;
    logic [STORE_AW-1:0] w_a, w_c, w_at;
    logic [8:0]          w_b;
    logic                w_we, w_bit, w_last;
    logic [STORE_AW-1:0] w_raddr, w_waddr;
    logic [7:0]          w_rdata, w_wdata;
    logic                w_is_wr;

    function automatic logic [STORE_AW-1:0] plane_addr(input logic [STORE_AW-1:0] at,
                                                       input logic [2:0] p);
        plane_addr = at + STORE_AW'({p, 1'b0});
    endfunction

    assign w_np    = (r_pln > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : r_pln;
    assign w_is_wr = (r_req.func == FN_WR_PIX) || (r_req.func == FN_WR_BIT);

    ibpa_mac u_mac (
        .i_clk  (i_clk),
        .i_load (w_load),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_c    (w_c),
        .o_y    (w_at)
    );

    ibpa_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared unit: first y*wpr + x/16, then that times the stride (twice the plane count) plus base and x[3]
    always_comb begin
        w_load = (r_state == ST_MUL0) || (r_state == ST_MUL1);
        if (r_state == ST_MUL0) begin
            w_a = STORE_AW'(r_req.y);
            w_b = r_wpr;
            w_c = STORE_AW'(r_req.x[11:4]);
        end else begin
            w_a = w_at;
            w_b = {4'd0, w_np, 1'b0};
            w_c = STORE_AW'(r_base) + STORE_AW'(r_req.x[3]);
        end
    end

    always_comb begin
        w_raddr = plane_addr(w_at, r_req.func[1] ? r_req.plane : r_iss[2:0]);
        w_waddr = plane_addr(w_at, r_req.func[1] ? r_req.plane : r_rp);
        w_bit   = (r_req.func == FN_WR_BIT) ? (r_req.value != 8'd0) : r_req.value[r_rp];
        w_wdata = w_bit ? (w_rdata | r_mask) : (w_rdata & ~r_mask);
        w_we    = (r_state == ST_ACC) && r_rv && w_is_wr;
        w_last  = r_rv && ({1'b0, r_rp} == (r_cnt - 4'd1));
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_iss   = r_iss;
        n_rv    = 1'b0;
        n_rp    = r_rp;
        n_rval  = r_rval;
        n_done  = 1'b0;
        n_res   = r_res;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_MUL0;
                end
            end
            ST_MUL0: begin
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                n_cnt  = r_req.func[1] ? 4'd1 : w_np;
                n_iss  = 4'd0;
                n_rval = 8'd0;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_iss < r_cnt) begin
                    n_iss = r_iss + 4'd1;
                    n_rv  = 1'b1;
                    n_rp  = r_iss[2:0];
                end
                if (r_rv && !w_is_wr && ((w_rdata & r_mask) != 8'd0)) begin
                    if (r_req.func == FN_RD_BIT) begin
                        n_rval[0] = 1'b1;
                    end else begin
                        n_rval[r_rp] = 1'b1;
                    end
                end
                // zero planes: nothing to touch
                if (w_last || (r_cnt == 4'd0)) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                    n_rv    = 1'b0;
                    n_res.byte_address = 16'(w_at);
                    n_res.bit_mask     = r_mask;
                    n_res.read_value   = w_is_wr ? 8'd0 : n_rval;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_rv    <= 1'b0;
            r_base  <= 16'd0;
            r_wpr   <= 9'd20;
            r_pln   <= 4'd4;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_rv    <= n_rv;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE: r_base <= i_cfg_data;
                    CFG_WPR:  r_wpr  <= i_cfg_data[8:0];
                    CFG_PLN:  r_pln  <= i_cfg_data[3:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_start) begin
            r_req  <= i_req;
            r_mask <= 8'd1 << (3'd7 - i_req.x[2:0]);
        end
        r_cnt  <= n_cnt;
        r_iss  <= n_iss;
        r_rp   <= n_rp;
        r_rval <= n_rval;
        r_res  <= n_res;
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
